@@ src/sas_pkg.sv @@
// ----------------------------------------------------------------------------
// sas_pkg
// shared types, codes and table field helpers for the sprite animation sequencer
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int MaxNodes   = 8;
  localparam int NodeW      = 3;
  localparam int FrameW     = 6;
  localparam int FtimeW     = 8;
  localparam int ElapsedW   = 10;
  localparam int StepW      = 8;
  localparam int OpW        = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;
  localparam int FcountTblW = MaxNodes * FrameW;
  localparam int FtimeTblW  = MaxNodes * FtimeW;
  localparam int NextTblW   = MaxNodes * NodeW;

  // operation codes
  localparam logic [OpW-1:0] OP_TICK = 2'd0;
  localparam logic [OpW-1:0] OP_MARK = 2'd1;
  localparam logic [OpW-1:0] OP_FLIP = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_TIME  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REVERSE     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_NEXT_STATE  = 2'd3;

  // each node loops back to itself after reset
  localparam logic [NextTblW-1:0] NextTblReset = 24'd16434824;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [StepW-1:0] elapsed_step;
    logic             flip_value;
  } in_word_t;

  typedef struct packed {
    logic [NodeW-1:0]  node_id;
    logic [FrameW-1:0] frame_index;
    logic              just_finished;
    logic              flipped;
  } out_word_t;

  typedef struct packed {
    logic [FcountTblW-1:0] frame_count_table;
    logic [FtimeTblW-1:0]  frame_time_table;
    logic [MaxNodes-1:0]   reverse_mask;
    logic [NextTblW-1:0]   next_state_table;
  } cfg_t;

  function automatic logic [FrameW-1:0] cnt_of(input cfg_t c, input logic [NodeW-1:0] n);
    return c.frame_count_table[FrameW*n +: FrameW];
  endfunction

  function automatic logic [FtimeW-1:0] ftime_of(input cfg_t c, input logic [NodeW-1:0] n);
    return c.frame_time_table[FtimeW*n +: FtimeW];
  endfunction

  function automatic logic rev_of(input cfg_t c, input logic [NodeW-1:0] n);
    return c.reverse_mask[n];
  endfunction

  function automatic logic [NodeW-1:0] next_of(input cfg_t c, input logic [NodeW-1:0] n);
    return c.next_state_table[NodeW*n +: NodeW];
  endfunction

endpackage

@@ src/sas_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sas_cfg_regs
// configuration register file, written through a plain indexed write port
// ----------------------------------------------------------------------------
module sas_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sas_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sas_pkg::CfgDataW-1:0]  cfg_wdata,
  output sas_pkg::cfg_t                 cfg
);
  import sas_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count_table <= '0;
      cfg_r.frame_time_table  <= '0;
      cfg_r.reverse_mask      <= '0;
      cfg_r.next_state_table  <= NextTblReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_COUNT: cfg_r.frame_count_table <= cfg_wdata[FcountTblW-1:0];
        REG_FRAME_TIME:  cfg_r.frame_time_table  <= cfg_wdata[FtimeTblW-1:0];
        REG_REVERSE:     cfg_r.reverse_mask      <= cfg_wdata[MaxNodes-1:0];
        REG_NEXT_STATE:  cfg_r.next_state_table  <= cfg_wdata[NextTblW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/sas_core.sv @@
// ----------------------------------------------------------------------------
// sas_core
// animation state registers and the single-pass update for one input word
// ----------------------------------------------------------------------------
module sas_core #(
  parameter int NUM_NODES = sas_pkg::MaxNodes
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  sas_pkg::in_word_t   in_word,
  input  sas_pkg::cfg_t       cfg,
  output sas_pkg::out_word_t  result
);
  import sas_pkg::*;

  localparam int NodeIw = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

  // the current node's frame lives in frame_r, the store keeps the others
  logic [FrameW-1:0]   store_r [NUM_NODES];
  logic [NodeW-1:0]    node_r, node_nxt;
  logic [FrameW-1:0]   frame_r, frame_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;
  logic                shown_r, shown_nxt;
  logic                flip_r, flip_nxt;
  logic                fin_r, fin_nxt;

  logic                store_we;
  logic [FrameW-1:0]   store_wval;

  logic [ElapsedW:0]   sum;
  logic [ElapsedW-1:0] t_sat;
  logic [FtimeW-1:0]   ftime;
  logic [FrameW-1:0]   cnt;
  logic                rev;
  logic [NodeW-1:0]    nx_raw, nx;
  logic [FrameW-1:0]   rst_frame;
  logic [FrameW-1:0]   fr;
  logic [ElapsedW-1:0] e;
  logic                done;

  always_comb begin
    sum       = {1'b0, elapsed_r} + (ElapsedW+1)'(in_word.elapsed_step);
    t_sat     = sum[ElapsedW] ? {ElapsedW{1'b1}} : sum[ElapsedW-1:0];
    ftime     = ftime_of(cfg, node_r);
    cnt       = cnt_of(cfg, node_r);
    rev       = rev_of(cfg, node_r);
    nx_raw    = next_of(cfg, node_r);
    nx        = ({1'b0, nx_raw} >= (NodeW+1)'(NUM_NODES)) ? node_r : nx_raw;
    rst_frame = rev ? cnt : '0;

    node_nxt    = node_r;
    frame_nxt   = frame_r;
    elapsed_nxt = elapsed_r;
    shown_nxt   = shown_r;
    flip_nxt    = flip_r;
    fin_nxt     = fin_r;
    store_we    = 1'b0;
    store_wval  = rst_frame;
    fr          = frame_r;
    e           = elapsed_r;
    done        = 1'b0;

    case (in_word.operation)
      OP_TICK: begin
        if (shown_r) begin
          e = t_sat;
          if (t_sat > ElapsedW'(ftime)) begin
            if (rev) begin
              if (frame_r == '0) begin
                done = 1'b1;
              end else begin
                fr = frame_r - FrameW'(1);
                e  = '0;
              end
            end else if (frame_r == cnt) begin
              done = 1'b1;
            end else begin
              // keep the remainder on a forward step
              fr = frame_r + FrameW'(1);
              e  = t_sat - ElapsedW'(ftime);
            end
          end
        end
        if (done) begin
          store_we    = 1'b1;
          node_nxt    = nx;
          frame_nxt   = (nx == node_r) ? rst_frame : store_r[nx[NodeIw-1:0]];
          elapsed_nxt = '0;
          shown_nxt   = 1'b0;
          fin_nxt     = 1'b1;
        end else begin
          frame_nxt   = fr;
          elapsed_nxt = e;
          fin_nxt     = 1'b0;
        end
      end
      OP_MARK: shown_nxt = 1'b1;
      OP_FLIP: flip_nxt  = in_word.flip_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r    <= '0;
      frame_r   <= '0;
      elapsed_r <= '0;
      shown_r   <= 1'b1;
      flip_r    <= 1'b0;
      fin_r     <= 1'b0;
      for (int i = 0; i < NUM_NODES; i++) begin
        store_r[i] <= '0;
      end
    end else if (step_en) begin
      node_r    <= node_nxt;
      frame_r   <= frame_nxt;
      elapsed_r <= elapsed_nxt;
      shown_r   <= shown_nxt;
      flip_r    <= flip_nxt;
      fin_r     <= fin_nxt;
      if (store_we) begin
        store_r[node_r[NodeIw-1:0]] <= store_wval;
      end
    end
  end

  always_comb begin
    result.node_id       = node_nxt;
    result.frame_index   = frame_nxt;
    result.just_finished = fin_nxt;
    result.flipped       = flip_nxt;
  end

endmodule

@@ src/sas_out_stage.sv @@
// ----------------------------------------------------------------------------
// sas_out_stage
// result register with valid/stall handshake, loads while the old word leaves
// ----------------------------------------------------------------------------
module sas_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sas_pkg::out_word_t  load_word,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_stall,
  output sas_pkg::out_word_t  out_data
);
  import sas_pkg::*;

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_word;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ src/sprite_animation_sequencer.sv @@
// the result word of an accepted input word is registered and valid in the next cycle
// throughput: one word per cycle while out_stall is low, set by the single state update pass
// in_stall rises only while a result word is held by out_stall
// reset (synchronous, rst_n low): node 0, all frames 0, time 0, shown, no flip
// configuration resets to zero tables and self-looping next nodes
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// steps an animation node graph on tick, rendered mark and flip words
// ----------------------------------------------------------------------------
module sprite_animation_sequencer #(
  parameter int NUM_NODES = sas_pkg::MaxNodes
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sas_pkg::in_word_t             in_data,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output sas_pkg::out_word_t            out_data,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [sas_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sas_pkg::CfgDataW-1:0]  cfg_wdata
);
  import sas_pkg::*;

  cfg_t      cfg;
  out_word_t result;
  logic      can_load;
  logic      accept;

  // a word is taken whenever the result register is empty or being drained
  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  // per-node tables: frame counts, frame times, reverse bits, next nodes
  sas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // state update: time accumulation, frame stepping and node hand-over
  sas_core #(
    .NUM_NODES (NUM_NODES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .in_word (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // result register parts the two channels
  sas_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_word (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
